FILE: sv/aalr_pkg.sv
package aalr_pkg;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 15;

	// operation codes of an input transaction
	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

	// the slope quotient is at most 256, so nine quotient bits suffice
	localparam int QUO_W = 9;
	localparam logic [3:0] DIV_FIRST_BIT = 4'd8;

	typedef struct packed {
		logic operation;
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
		logic signed [15:0] end_x;
		logic signed [15:0] end_y;
		logic [15:0] fore_colour;
		logic [15:0] back_colour;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] pixel_x;
		logic signed [15:0] pixel_y;
		logic [15:0] pixel_colour;
		logic visible;
		logic last_of_step;
		logic line_done;
	} out_item_t;

	typedef struct packed {
		logic start;
		logic div_step;
		logic emit;
		logic sel_lower;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic active;
		logic point_only;
		logic frac_zero;
		logic frac_full;
	} status_t;

endpackage

FILE: sv/aalr_in_if.sv
interface aalr_in_if import aalr_pkg::*; ();
	logic valid;
	logic ready;
	in_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: sv/aalr_out_if.sv
interface aalr_out_if import aalr_pkg::*; ();
	logic valid;
	logic ready;
	out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: sv/aalr_cfg_if.sv
interface aalr_cfg_if import aalr_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] wdata;

	modport source(output valid, output index, output wdata, input ready);
	modport sink(input valid, input index, input wdata, output ready);
endinterface

FILE: sv/aalr_ctrl.sv
module aalr_ctrl import aalr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_op,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input status_t status,
	output cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV = 2'd1;
	localparam logic [1:0] ST_EMIT_A = 2'd2;
	localparam logic [1:0] ST_EMIT_B = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_op == OP_START) begin
						cmd.start = 1'b1;
						state_d = ST_DIV;
					end else if (status.active) begin
						state_d = ST_EMIT_A;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT_A: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					// upper pixel unless its alpha is zero
					cmd.sel_lower = !status.point_only && status.frac_full;
					cmd.last = status.point_only || status.frac_zero || status.frac_full;
					state_d = cmd.last ? ST_IDLE : ST_EMIT_B;
				end
			end
			ST_EMIT_B: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					cmd.sel_lower = 1'b1;
					cmd.last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: sv/aalr_dp.sv
module aalr_dp import aalr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	output status_t status,
	input in_item_t in_data,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_wdata,
	output out_item_t out_data
);

	// blend one colour channel: (f*a + b*(255-a) + 127) / 255
	function automatic logic [5:0] blend_chan(input logic [5:0] f, input logic [5:0] b,
			input logic [7:0] a);
		logic [7:0] na;
		logic [13:0] prod_f;
		logic [13:0] prod_b;
		logic [14:0] sum;
		logic [14:0] quo;
		na = 8'd255 - a;
		prod_f = 14'(f) * 14'(a);
		prod_b = 14'(b) * 14'(na);
		sum = 15'(prod_f) + 15'(prod_b) + 15'd127;
		// exact divide by 255 for sums below 65535
		quo = (sum + 15'd1 + (sum >> 8)) >> 8;
		blend_chan = quo[5:0];
	endfunction

	logic [CFG_DATA_W-1:0] width_q;
	logic [CFG_DATA_W-1:0] height_q;

	logic [15:0] major_q;
	logic [15:0] major_end_q;
	logic [23:0] minor_q;
	logic signed [9:0] slope_q;
	logic steep_q;
	logic point_q;
	logic active_q;
	logic [15:0] fore_q;
	logic [15:0] back_q;
	logic [23:0] rem_q;
	logic [15:0] dvs_q;
	logic [QUO_W-1:0] quo_q;
	logic [3:0] idx_q;
	logic neg_q;
	out_item_t out_q;

	// start transaction setup
	logic signed [16:0] dx_raw;
	logic signed [16:0] dy_raw;
	logic [16:0] adx;
	logic [16:0] ady;
	logic steep;
	logic signed [15:0] a0;
	logic signed [15:0] a1;
	logic signed [15:0] b0;
	logic signed [15:0] b1;
	logic swap;
	logic signed [15:0] maj_lo;
	logic signed [15:0] maj_hi;
	logic signed [15:0] min_lo;
	logic signed [15:0] min_hi;
	logic [16:0] dx;
	logic [16:0] dy;
	logic [16:0] abs_dy;

	always_comb begin
		dx_raw = 17'(in_data.end_x) - 17'(in_data.start_x);
		dy_raw = 17'(in_data.end_y) - 17'(in_data.start_y);
		adx = dx_raw[16] ? 17'(-dx_raw) : dx_raw;
		ady = dy_raw[16] ? 17'(-dy_raw) : dy_raw;
		steep = ady > adx;
		a0 = steep ? in_data.start_y : in_data.start_x;
		a1 = steep ? in_data.end_y : in_data.end_x;
		b0 = steep ? in_data.start_x : in_data.start_y;
		b1 = steep ? in_data.end_x : in_data.end_y;
		swap = a0 > a1;
		maj_lo = swap ? a1 : a0;
		maj_hi = swap ? a0 : a1;
		min_lo = swap ? b1 : b0;
		min_hi = swap ? b0 : b1;
		dx = 17'(maj_hi) - 17'(maj_lo);
		dy = 17'(min_hi) - 17'(min_lo);
		abs_dy = dy[16] ? 17'(-dy) : dy;
	end

	// slope divider: one quotient bit a cycle, most significant first
	logic [24:0] div_shifted;
	logic [24:0] div_diff;
	logic div_ge;
	logic [QUO_W-1:0] quo_next;
	logic [9:0] slope_next;

	always_comb begin
		div_shifted = 25'(dvs_q) << idx_q;
		div_diff = {1'b0, rem_q} - div_shifted;
		div_ge = !div_diff[24];
		quo_next = {quo_q[QUO_W-2:0], div_ge};
		slope_next = neg_q ? 10'(-{1'b0, quo_next}) : {1'b0, quo_next};
	end

	// pixel generation
	logic [7:0] frac;
	logic [15:0] minor_int;
	logic [15:0] minor_sel;
	logic [7:0] alpha;
	logic [5:0] blend_r;
	logic [5:0] blend_g;
	logic [5:0] blend_b;
	logic [15:0] blended;
	logic [15:0] px;
	logic [15:0] py;
	logic line_end;

	always_comb begin
		frac = minor_q[7:0];
		minor_int = minor_q[23:8];
		minor_sel = cmd.sel_lower ? minor_int + 16'd1 : minor_int;
		alpha = cmd.sel_lower ? frac : ~frac;
		blend_r = blend_chan({1'b0, fore_q[15:11]}, {1'b0, back_q[15:11]}, alpha);
		blend_g = blend_chan(fore_q[10:5], back_q[10:5], alpha);
		blend_b = blend_chan({1'b0, fore_q[4:0]}, {1'b0, back_q[4:0]}, alpha);
		blended = {blend_r[4:0], blend_g, blend_b[4:0]};
		px = steep_q ? minor_sel : major_q;
		py = steep_q ? major_q : minor_sel;
		line_end = point_q || (major_q == major_end_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= CFG_DATA_W'(1);
			height_q <= CFG_DATA_W'(1);
			active_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SCREEN_WIDTH: width_q <= cfg_wdata;
					REG_SCREEN_HEIGHT: height_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.start) begin
				active_q <= 1'b1;
				idx_q <= DIV_FIRST_BIT;
			end else if (cmd.div_step) begin
				idx_q <= idx_q - 4'd1;
			end else if (cmd.emit && cmd.last && line_end) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			steep_q <= steep;
			major_q <= maj_lo;
			major_end_q <= maj_hi;
			minor_q <= {min_lo, 8'd128};
			point_q <= (dx == 17'd0);
			fore_q <= in_data.fore_colour;
			back_q <= in_data.back_colour;
			rem_q <= {abs_dy[15:0], 8'd0};
			dvs_q <= dx[15:0];
			quo_q <= '0;
			neg_q <= dy[16];
		end else if (cmd.div_step) begin
			if (div_ge) begin
				rem_q <= div_diff[23:0];
			end
			quo_q <= quo_next;
			if (idx_q == 4'd0) begin
				slope_q <= point_q ? 10'sd0 : slope_next;
			end
		end else if (cmd.emit && cmd.last && !line_end) begin
			// advance to the next column
			minor_q <= minor_q + {{14{slope_q[9]}}, slope_q};
			major_q <= major_q + 16'd1;
		end
		if (cmd.emit) begin
			out_q.pixel_x <= px;
			out_q.pixel_y <= py;
			out_q.pixel_colour <= point_q ? fore_q : blended;
			out_q.visible <= !px[15] && !py[15] && (px[14:0] < width_q) &&
				(py[14:0] < height_q);
			out_q.last_of_step <= cmd.last;
			out_q.line_done <= cmd.last && line_end;
		end
	end

	assign out_data = out_q;

	assign status.div_last = (idx_q == 4'd0);
	assign status.active = active_q;
	assign status.point_only = point_q;
	assign status.frac_zero = (frac == 8'd0);
	assign status.frac_full = (frac == 8'hFF);

endmodule

FILE: sv/antialiased_line_rasterizer_top.sv
// Anti-aliased line rasterizer with RGB565 blending. A start transaction
// (operation 0) loads both endpoints and the line and background colours and
// emits nothing; it replaces any line in progress. Each step transaction
// (operation 1) walks one column of the major axis and emits one or two
// pixels, the last of which carries last_of_step; the last pixel of the line
// also carries line_done, after which steps are ignored until the next start.
// Pixels outside screen_width x screen_height are still emitted, with
// visible low. A start transaction sets up the endpoints and then runs the
// slope divider, which produces one quotient bit per cycle, before the block
// takes another transaction. A step transaction is accepted and then emits
// its pixels one at a time, each waiting while the output register still
// holds a pixel the consumer has not taken. The output register decouples
// the two sides: a new transaction is accepted while the previous pixel
// still waits to be taken. Configuration writes are accepted every cycle
// and should only be issued while no line step is in flight.
module antialiased_line_rasterizer_top import aalr_pkg::*; (
	input logic clk,
	input logic arst_n,
	aalr_in_if.sink in_ch,
	aalr_out_if.source out_ch,
	aalr_cfg_if.sink cfg_ch
);

	cmd_t cmd;
	status_t status;

	// configuration writes never stall
	assign cfg_ch.ready = 1'b1;

	// sequencer: start setup, divider iterations, one pixel per emit cycle
	aalr_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_op(in_ch.data.operation),
		.in_ready(in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.status(status),
		.cmd(cmd)
	);

	// line state, slope divider, blend and visibility, output payload register
	aalr_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.in_data(in_ch.data),
		.cfg_we(cfg_ch.valid),
		.cfg_index(cfg_ch.index),
		.cfg_wdata(cfg_ch.wdata),
		.out_data(out_ch.data)
	);

`ifndef SYNTHESIS
	// never overwrite a pixel the consumer has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_ch.valid || out_ch.ready))
		else $error("pixel overwritten in output register");

	// the end of a line is always the end of a step
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.data.line_done) |-> out_ch.data.last_of_step)
		else $error("line_done without last_of_step");

	// after the final pixel of a step the block takes the next transaction
	a_ready_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> in_ch.ready)
		else $error("not ready after finishing a step");

	// a step transaction never starts emitting on an idle line
	a_step_needs_line: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && in_ch.data.operation == OP_STEP &&
		!status.active) |=> in_ch.ready)
		else $error("step on idle line did not return to idle");
`endif

endmodule

FILE: dv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import aalr_pkg::*;

	// Longest quiet stretch tolerated: a start transaction plus a full input
	// gap, a full output stall and the settle pause, many times over.
	localparam int STALL_LIMIT = 2000;
	// A start transaction keeps the block busy in the slope divider without any
	// pixel to show for it; wait this long before touching the registers.
	localparam int SETTLE_CYCLES = 24;
	localparam int IN_W = $bits(in_item_t);

	logic clk;
	logic arst_n;

	aalr_in_if in_ch();
	aalr_out_if out_ch();
	aalr_cfg_if cfg_ch();

	antialiased_line_rasterizer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	// Predictor state: screen size plus the line walker.
	logic [14:0] scr_w = 15'd1;
	logic [14:0] scr_h = 15'd1;
	logic [15:0] pos_major = '0;
	logic [15:0] end_major = '0;
	logic [31:0] minor_acc = '0;   // 24.8 fixed point minor coordinate
	int slope_q = 0;               // 24.8 fixed point, signed
	bit swapped = 1'b0;            // steep line: x and y exchanged
	bit single_point = 1'b0;
	bit line_busy = 1'b0;
	logic [15:0] fg_held = '0;
	logic [15:0] bg_held = '0;

	// Pixels predicted but not yet seen on the output channel, oldest first.
	out_item_t expected_pixels[$];

	// When set, neither side inserts idle cycles.
	bit calm = 1'b0;

	int fail_count = 0;
	int pixels_checked = 0;
	int lines_started = 0;
	int steps_sent = 0;
	int settings_applied = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Blend one RGB565 colour pair per channel with rounding.
	function automatic logic [15:0] mix_rgb565(input logic [15:0] fg, input logic [15:0] bg,
			input int alpha);
		int na;
		int r;
		int g;
		int b;
		na = 255 - alpha;
		r = (int'(fg[15:11]) * alpha + int'(bg[15:11]) * na + 127) / 255;
		g = (int'(fg[10:5]) * alpha + int'(bg[10:5]) * na + 127) / 255;
		b = (int'(fg[4:0]) * alpha + int'(bg[4:0]) * na + 127) / 255;
		return {r[4:0], g[5:0], b[4:0]};
	endfunction

	// Map major/minor back to screen x/y and judge visibility on the wrapped values.
	function automatic out_item_t make_pixel(input logic [15:0] maj, input logic [15:0] mnr,
			input logic [15:0] col);
		out_item_t p;
		logic [15:0] px;
		logic [15:0] py;
		px = swapped ? mnr : maj;
		py = swapped ? maj : mnr;
		p.pixel_x = px;
		p.pixel_y = py;
		p.pixel_colour = col;
		p.visible = !px[15] && !py[15] && (px[14:0] < scr_w) && (py[14:0] < scr_h);
		p.last_of_step = 1'b0;
		p.line_done = 1'b0;
		return p;
	endfunction

	// Advance the line walker for one accepted transaction and queue its pixels.
	task automatic predict_pixels(input in_item_t it);
		int ax;
		int ay;
		int bx;
		int by;
		int t;
		int spanx;
		int spany;
		int ddx;
		int ddy;
		int n;
		logic [15:0] row;
		logic [7:0] frac;
		bit done;
		out_item_t pix[2];
		if (it.operation == OP_START) begin
			ax = $signed(it.start_x);
			ay = $signed(it.start_y);
			bx = $signed(it.end_x);
			by = $signed(it.end_y);
			spanx = (bx > ax) ? bx - ax : ax - bx;
			spany = (by > ay) ? by - ay : ay - by;
			swapped = spany > spanx;
			if (swapped) begin
				t = ax; ax = ay; ay = t;
				t = bx; bx = by; by = t;
			end
			// walk the major axis upward
			if (ax > bx) begin
				t = ax; ax = bx; bx = t;
				t = ay; ay = by; by = t;
			end
			ddx = bx - ax;
			ddy = by - ay;
			fg_held = it.fore_colour;
			bg_held = it.back_colour;
			pos_major = ax[15:0];
			end_major = bx[15:0];
			minor_acc = 32'(ay * 256 + 128);
			single_point = (ddx == 0);
			slope_q = single_point ? 0 : (ddy * 256) / ddx;
			line_busy = 1'b1;
		end else if (line_busy) begin
			row = minor_acc[23:8];
			frac = minor_acc[7:0];
			done = (pos_major == end_major) || single_point;
			n = 0;
			if (single_point) begin
				pix[0] = make_pixel(pos_major, row, fg_held);
				n = 1;
			end else begin
				// upper pixel is dropped at full coverage of the lower one, and vice versa
				if (frac != 8'hFF) begin
					pix[n] = make_pixel(pos_major, row, mix_rgb565(fg_held, bg_held, 255 - frac));
					n++;
				end
				if (frac != 8'h00) begin
					pix[n] = make_pixel(pos_major, row + 16'd1,
						mix_rgb565(fg_held, bg_held, int'(frac)));
					n++;
				end
			end
			pix[n - 1].last_of_step = 1'b1;
			if (done) begin
				pix[n - 1].line_done = 1'b1;
				line_busy = 1'b0;
			end else begin
				minor_acc = minor_acc + 32'(slope_q);
				pos_major = pos_major + 16'd1;
			end
			for (int k = 0; k < n; k++)
				expected_pixels.push_back(pix[k]);
		end
	endtask

	// Drive one transaction, optionally after an idle burst, and hold it until
	// accepted. Valid is left high so a back-to-back transaction needs no toggle.
	task automatic push_item(input in_item_t it);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_pixels(it);
		if (it.operation == OP_START)
			lines_started++;
		else
			steps_sent++;
	endtask

	task automatic send_start(input logic [15:0] x0, input logic [15:0] y0,
			input logic [15:0] x1, input logic [15:0] y1,
			input logic [15:0] fg, input logic [15:0] bg);
		in_item_t it;
		it.operation = OP_START;
		it.start_x = x0;
		it.start_y = y0;
		it.end_x = x1;
		it.end_y = y1;
		it.fore_colour = fg;
		it.back_colour = bg;
		push_item(it);
	endtask

	// Step transactions carry random junk in the fields the block ignores.
	task automatic send_step();
		in_item_t it;
		it = in_item_t'(IN_W'({$urandom, $urandom, $urandom, $urandom}));
		it.operation = OP_STEP;
		push_item(it);
	endtask

	// Drop valid, wait for every predicted pixel, then let a start in flight finish.
	task automatic drain_pipeline();
		in_ch.valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		if (idx == REG_SCREEN_WIDTH)
			scr_w = value;
		else
			scr_h = value;
	endtask

	// Registers change only with the block idle.
	task automatic set_screen(input logic [14:0] w, input logic [14:0] h);
		drain_pipeline();
		write_register(REG_SCREEN_WIDTH, w);
		write_register(REG_SCREEN_HEIGHT, h);
		cfg_ch.valid <= 1'b0;
		settings_applied++;
	endtask

	function automatic logic [14:0] pick_extent();
		case ($urandom_range(0, 5))
			0: return 15'd1;
			1: return 15'h7FFF;
			2: return 15'($urandom_range(1, 32767));
			default: return 15'($urandom_range(2, 96));
		endcase
	endfunction

	// Random line traffic: mostly well-formed lines walked to the end, some cut
	// short by a new start, some spanning the whole coordinate range, plus noise.
	task automatic run_lines(input int budget);
		int kind;
		int limit;
		logic [15:0] x0;
		logic [15:0] y0;
		logic [15:0] x1;
		logic [15:0] y1;
		in_item_t junk;
		while (budget > 0) begin
			kind = $urandom_range(0, 19);
			if (kind == 0) begin
				// noise: any opcode, any content
				junk = in_item_t'(IN_W'({$urandom, $urandom, $urandom, $urandom}));
				if (junk.operation == OP_START || line_busy)
					budget--;
				push_item(junk);
				continue;
			end
			if (kind <= 2) begin
				x0 = 16'($urandom);
				y0 = 16'($urandom);
				x1 = 16'($urandom);
				y1 = 16'($urandom);
				limit = $urandom_range(1, 6);
			end else begin
				x0 = 16'($urandom_range(0, 110)) - 16'd10;
				y0 = 16'($urandom_range(0, 110)) - 16'd10;
				if (kind == 3) begin
					x1 = x0;
					y1 = y0;
				end else begin
					x1 = x0 + 16'($urandom_range(0, 48)) - 16'd24;
					y1 = y0 + 16'($urandom_range(0, 48)) - 16'd24;
				end
				limit = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 70000;
			end
			send_start(x0, y0, x1, y1, 16'($urandom), 16'($urandom));
			budget--;
			while (line_busy && limit > 0 && budget > 0) begin
				send_step();
				budget--;
				limit--;
			end
			// a step after the line is finished must be swallowed
			if (!line_busy && $urandom_range(0, 7) == 0)
				send_step();
		end
	endtask

	// Reset screen is 1x1: idle steps, a single point and a short line across it.
	task automatic test_reset_defaults();
		send_step();
		send_start(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'h0000);
		send_step();
		send_step();
		send_start(-16'sd1, 16'd0, 16'd1, 16'd0, 16'hA5A5, 16'h5A5A);
		repeat (3) send_step();
	endtask

	// Largest screen: orientations, reversed endpoints, skipped upper and lower
	// pixels, colour extremes, full-range spans, row wrap and line replacement.
	task automatic test_directed_lines();
		set_screen(15'h7FFF, 15'h7FFF);
		send_start(16'd5, 16'd3, 16'd2, 16'd1, 16'hFFFF, 16'h0000);
		repeat (3) send_step();
		// slope 127: second column lands at frac 255, upper pixel skipped
		send_start(16'd0, 16'd0, 16'd255, 16'd127, 16'hF800, 16'h07E0);
		repeat (2) send_step();
		// slope 128 replaces the line in flight: second column at frac 0
		send_start(16'd0, 16'd0, 16'd4, 16'd2, 16'h0000, 16'hFFFF);
		repeat (2) send_step();
		// steep with falling minor axis
		send_start(16'd10, 16'd0, 16'd7, 16'd20, 16'h001F, 16'hFFE0);
		repeat (3) send_step();
		send_start(-16'sd32768, -16'sd32768, 16'd32767, 16'd32767, 16'h0000, 16'hFFFF);
		send_step();
		// lower pixel of the top row wraps to the most negative row
		send_start(16'd100, 16'd32767, 16'd110, 16'd32767, 16'h7BEF, 16'h8410);
		send_step();
		send_start(16'd32767, -16'sd32768, -16'sd32768, 16'd32767, 16'hFFFF, 16'hFFFF);
		send_step();
	endtask

	// A zero extent on either axis hides every pixel.
	task automatic test_zero_screen();
		set_screen(15'd0, 15'h7FFF);
		send_start(16'd0, 16'd0, 16'd1, 16'd1, 16'hFFFF, 16'h0000);
		repeat (2) send_step();
		set_screen(15'h7FFF, 15'd0);
		send_start(16'd0, 16'd0, 16'd1, 16'd1, 16'hFFFF, 16'h0000);
		repeat (2) send_step();
	endtask

	task automatic test_random_lines();
		for (int phase = 0; phase < 8; phase++) begin
			set_screen(pick_extent(), pick_extent());
			calm = ($urandom_range(0, 3) == 0);
			run_lines(130);
		end
	endtask

	// Closing stretch with both sides running flat out.
	task automatic test_steady_stream();
		set_screen(15'($urandom_range(8, 64)), 15'($urandom_range(8, 64)));
		calm = 1'b1;
		run_lines(180);
	endtask

	task automatic compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	// Check each pixel transaction against the oldest prediction.
	task automatic check_pixel(input out_item_t got);
		out_item_t want;
		if (expected_pixels.size() == 0) begin
			$error("pixel with nothing expected: x=%0d y=%0d colour=0x%0h",
				got.pixel_x, got.pixel_y, got.pixel_colour);
			fail_count++;
			return;
		end
		want = expected_pixels.pop_front();
		compare_field("pixel_x", want.pixel_x, got.pixel_x);
		compare_field("pixel_y", want.pixel_y, got.pixel_y);
		compare_field("pixel_colour", want.pixel_colour, got.pixel_colour);
		compare_field("visible", 16'(want.visible), 16'(got.visible));
		compare_field("last_of_step", 16'(want.last_of_step), 16'(got.last_of_step));
		compare_field("line_done", 16'(want.line_done), 16'(got.line_done));
		pixels_checked++;
	endtask

	// Output side: hold ready low in random bursts unless the run is calm.
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	// Sample on the rising edge, before any of this step's updates land.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready)
				check_pixel(out_ch.data);
		end
	end

	// Abort if no transaction moves on any channel for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$error("no transaction for %0d cycles", STALL_LIMIT);
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.data <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.wdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_directed_lines();
		test_zero_screen();
		test_random_lines();
		test_steady_stream();
		drain_pipeline();

		if (expected_pixels.size() != 0) begin
			$error("%0d predicted pixels never arrived", expected_pixels.size());
			fail_count++;
		end
		$display("Walked %0d lines with %0d step transactions over %0d screen sizes;",
			lines_started, steps_sent, settings_applied);
		$display("%0d pixels compared, %0d mismatches.", pixels_checked, fail_count);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
